// ----- rtl/core/cdq_pkg.sv -----
// cdq_pkg: request codes, field widths and controller command type for the circular deque.
// No dependencies; used by cdq_ctrl and cdq_dp.
package cdq_pkg;

    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_PEEK       = 3'd4;

    localparam int KIND_WIDTH  = 3;
    localparam int FIELD_WIDTH = 32;
    localparam int COUNT_WIDTH = 5;
    localparam int CAP_WIDTH   = 5;

    typedef struct packed {
        logic load;   // capture request beat
        logic exec;   // apply request to pointers and store
    } cmd_t;

endpackage

// ----- rtl/core/cdq_ctrl.sv -----
// cdq_ctrl: sequencer for the circular deque (take beat, execute, read, respond).
// Depends on cdq_pkg.
module cdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cdq_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   exec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            exec_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ready_reg && in_valid)
                    begin
                        in_ready_reg <= 1'b0;
                        exec_reg     <= 1'b1;
                        state_reg    <= S_EXEC;
                    end
                    else
                    begin
                        in_ready_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    exec_reg  <= 1'b0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    in_ready_reg  <= 1'b0;
                    out_valid_reg <= 1'b0;
                    exec_reg      <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_ready_reg && in_valid;
    assign cmd.exec  = exec_reg;

endmodule

// ----- rtl/core/cdq_dp.sv -----
// cdq_dp: deque datapath - request registers, pointers, count, capacity, ring store.
// Depends on cdq_pkg; driven by cdq_ctrl commands.
module cdq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  cdq_pkg::cmd_t                             cmd,
    input  logic                                      cfg_we,
    input  logic        [cdq_pkg::CAP_WIDTH-1:0]      cfg_wdata,
    input  logic        [cdq_pkg::KIND_WIDTH-1:0]     kind,
    input  logic signed [cdq_pkg::FIELD_WIDTH-1:0]    push_value,
    output logic                                      accepted,
    output logic signed [cdq_pkg::FIELD_WIDTH-1:0]    front_value,
    output logic signed [cdq_pkg::FIELD_WIDTH-1:0]    rear_value,
    output logic        [cdq_pkg::COUNT_WIDTH-1:0]    entry_count,
    output logic                                      is_empty,
    output logic                                      is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = cdq_pkg::FIELD_WIDTH;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [cdq_pkg::KIND_WIDTH-1:0] kind_reg;
    logic [FW-1:0]                  value_reg;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  cap_reg, cap_next;
    logic                           accepted_reg, accepted_next;
    logic [DATA_WIDTH-1:0]          rd_front_reg, rd_rear_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [AW-1:0]         head_dec, head_inc, tail_dec, tail_inc;
    logic [31:0]           cap_clamp;
    logic                  ok;
    logic [DATA_WIDTH:0]   push_ext;
    logic [64:0]           front_ext, rear_ext;

    assign head_dec = (head_reg == '0) ? AW'(cap_reg - 1'b1) : head_reg - 1'b1;
    assign tail_dec = (tail_reg == '0) ? AW'(cap_reg - 1'b1) : tail_reg - 1'b1;
    assign head_inc = ((CW'(head_reg) + CW'(1)) >= cap_reg) ? '0 : head_reg + 1'b1;
    assign tail_inc = ((CW'(tail_reg) + CW'(1)) >= cap_reg) ? '0 : tail_reg + 1'b1;

    assign push_ext = (DATA_WIDTH + 1)'({33'd0, value_reg});
    assign wr_data  = push_ext[DATA_WIDTH-1:0];

    always_comb
    begin
        cap_clamp = {27'd0, cfg_wdata};
        if (cap_clamp == 32'd0)
        begin
            cap_clamp = 32'd1;
        end
        if (cap_clamp > 32'(DEPTH))
        begin
            cap_clamp = 32'(DEPTH);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        ok         = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        if (cmd.exec)
        begin
            case (kind_reg)
                cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK:
                begin
                    if (count_reg < cap_reg)
                    begin
                        ok         = 1'b1;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            wr_addr   = '0;
                        end
                        else if (kind_reg == cdq_pkg::KIND_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            wr_addr   = head_dec;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            wr_addr   = tail_inc;
                        end
                    end
                end
                cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK:
                begin
                    if (count_reg != '0)
                    begin
                        ok = 1'b1;
                        if (count_reg == CW'(1))
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            if (kind_reg == cdq_pkg::KIND_POP_FRONT)
                            begin
                                head_next = head_inc;
                            end
                            else
                            begin
                                tail_next = tail_dec;
                            end
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                cdq_pkg::KIND_PEEK:
                begin
                    ok = 1'b1;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        if (cfg_we)
        begin
            cap_next   = cap_clamp[CW-1:0];
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        accepted_next = cmd.exec ? ok : accepted_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            cap_reg      <= CW'(DEPTH);
            accepted_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            accepted_reg <= accepted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            value_reg <= push_value;
        end
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_front_reg <= mem[head_reg];
        rd_rear_reg  <= mem[tail_reg];
    end

    assign front_ext = 65'($signed(rd_front_reg));
    assign rear_ext  = 65'($signed(rd_rear_reg));

    assign accepted    = accepted_reg;
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == cap_reg);
    assign entry_count = cdq_pkg::COUNT_WIDTH'(count_reg);
    assign front_value = is_empty ? '1 : front_ext[FW-1:0];
    assign rear_value  = is_empty ? '1 : rear_ext[FW-1:0];

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("count above capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == '0 && tail_reg == '0)
        else $error("empty deque with nonzero pointers");

    a_full_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !cfg_we && count_reg == cap_reg &&
        (kind_reg == cdq_pkg::KIND_PUSH_FRONT || kind_reg == cdq_pkg::KIND_PUSH_BACK)
        |=> !accepted_reg && $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("push into full deque changed state");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec && !cfg_we |=> $stable(count_reg) && $stable(head_reg)
        && $stable(tail_reg) && $stable(accepted_reg))
        else $error("state changed without a request");

    a_no_load_during_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !cmd.load)
        else $error("request captured while executing");
`endif

endmodule

// ----- rtl/core/circular_deque.sv -----
// circular_deque: double-ended queue in a ring store with settable capacity.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp.
//
// Request channel (in_valid/in_ready) carries kind and push_value; one beat
// is one request: push front, push back, pop front, pop back or peek.
// Result channel (out_valid/out_ready) returns one beat per request with
// accepted, front/rear values (-1 when empty), entry_count and flags.
// Configuration: cfg_we with cfg_wdata sets the capacity in use (0 reads as
// 1, values above DEPTH as DEPTH) and empties the queue; write only when idle.
//
// Timing: after the request beat the controller steps through S_EXEC (execute)
// and S_READ (registered store read), then raises out_valid in S_RESP. One
// request is in flight at a time; the pace is set by the controller sequence
// and the registered read of the ring store.
// A stalled result holds its value and no new request beat is taken until
// it is delivered.
// Reset: queue empty, both pointers zero, capacity DEPTH, no result pending.
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [cdq_pkg::CAP_WIDTH-1:0]   cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [cdq_pkg::KIND_WIDTH-1:0]  kind,
    input  logic signed [cdq_pkg::FIELD_WIDTH-1:0] push_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   accepted,
    output logic signed [cdq_pkg::FIELD_WIDTH-1:0] front_value,
    output logic signed [cdq_pkg::FIELD_WIDTH-1:0] rear_value,
    output logic        [cdq_pkg::COUNT_WIDTH-1:0] entry_count,
    output logic                                   is_empty,
    output logic                                   is_full
);

    cdq_pkg::cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .push_value  (push_value),
        .accepted    (accepted),
        .front_value (front_value),
        .rear_value  (rear_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule
